[rtl/core/ssu_pkg.sv]
// Shared types, constants and helpers of the substring search unit.
`default_nettype none

package ssu_pkg;

   localparam int PATTERN_MAX_DEFAULT   = 16;
   localparam int POSITION_BITS_DEFAULT = 16;

   localparam int PATTERN_STORE_BYTES = 16;
   localparam int LENGTH_W            = 5;
   localparam int LIMIT_W             = 16;
   localparam int MATCH_POS_W         = 16;
   localparam int CSR_DATA_W          = 64;
   localparam int CSR_ADDR_W          = 6;
   localparam int CSR_INDEX_W         = 3;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_PATTERN_FIRST = 3'd0,
      REG_PATTERN_LAST  = 3'd1,
      REG_PATTERN_LEN   = 3'd2,
      REG_DIRECTION     = 3'd3,
      REG_POS_LIMIT     = 3'd4
   } reg_index_type;

   typedef struct packed {
      logic [8*PATTERN_STORE_BYTES-1:0] pattern;
      logic [LENGTH_W-1:0]              length;
      logic                             backward;
      logic [LIMIT_W-1:0]               limit;
   } cfg_type;

   function automatic logic [7:0] pattern_byte(
      input logic [8*PATTERN_STORE_BYTES-1:0] pattern,
      input int                               k
   );
      logic [7:0] b;
      b = 8'h00;
      if (k < PATTERN_STORE_BYTES) begin
         b = pattern[8*k +: 8];
      end
      return b;
   endfunction

endpackage

`default_nettype wire

[rtl/core/ssu_cell.sv]
// One compare cell of the match chain: tracks a partial match through one pattern byte.
`default_nettype none

module ssu_cell (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       advance,
   input  wire logic       flush,
   input  wire logic [7:0] text_byte,
   input  wire logic [7:0] pattern_byte,
   input  wire logic       prev_match,
   output logic            match_now,
   output logic            match_ff
);

   logic match_in;

   assign match_now = prev_match && (text_byte == pattern_byte);

   always_comb begin
      match_in = match_ff;
      if (advance) begin
         match_in = flush ? 1'b0 : match_now;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         match_ff <= 1'b0;
      end else begin
         match_ff <= match_in;
      end
   end

endmodule

`default_nettype wire

[rtl/core/ssu_csr.sv]
// Configuration register file with APB-style access.
`default_nettype none

module ssu_csr (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          psel,
   input  wire logic                          penable,
   input  wire logic                          pwrite,
   input  wire logic [ssu_pkg::CSR_ADDR_W-1:0] paddr,
   input  wire logic [ssu_pkg::CSR_DATA_W-1:0] pwdata,
   output logic      [ssu_pkg::CSR_DATA_W-1:0] prdata,
   output logic                               pready,
   output ssu_pkg::cfg_type                   cfg
);

   import ssu_pkg::*;

   cfg_type                cfg_ff;
   cfg_type                cfg_in;
   logic                   wr_en;
   logic [CSR_INDEX_W-1:0] index;

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite;
   assign index  = paddr[CSR_ADDR_W-1 -: CSR_INDEX_W];
   assign cfg    = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (index)
            REG_PATTERN_FIRST: cfg_in.pattern[63:0]   = pwdata;
            REG_PATTERN_LAST:  cfg_in.pattern[127:64] = pwdata;
            REG_PATTERN_LEN:   cfg_in.length          = pwdata[LENGTH_W-1:0];
            REG_DIRECTION:     cfg_in.backward        = pwdata[0];
            REG_POS_LIMIT:     cfg_in.limit           = pwdata[LIMIT_W-1:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (index)
         REG_PATTERN_FIRST: prdata = cfg_ff.pattern[63:0];
         REG_PATTERN_LAST:  prdata = cfg_ff.pattern[127:64];
         REG_PATTERN_LEN:   prdata = CSR_DATA_W'(cfg_ff.length);
         REG_DIRECTION:     prdata = CSR_DATA_W'(cfg_ff.backward);
         REG_POS_LIMIT:     prdata = CSR_DATA_W'(cfg_ff.limit);
         default:           prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pattern  <= '0;
         cfg_ff.length   <= LENGTH_W'(1);
         cfg_ff.backward <= 1'b0;
         cfg_ff.limit    <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

[rtl/core/substring_search_unit.sv]
// Substring search unit: streaming pattern match over a chain of compare cells.
// The result is registered, valid in the cycle after the end-of-text request is taken.
// Throughput: one text byte per cycle when not stalled; cells advance on each request.
// The result register stalls input only while it is full and not being taken.
// Synchronous reset clears the chain, counters and result valid, not the result data.
`default_nettype none

module substring_search_unit #(
   parameter int PATTERN_MAX   = ssu_pkg::PATTERN_MAX_DEFAULT,
   parameter int POSITION_BITS = ssu_pkg::POSITION_BITS_DEFAULT
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_ready,
   input  wire logic [7:0]                     req_text_byte,
   input  wire logic                           req_end_of_text,
   output logic                                rsp_valid,
   input  wire logic                           rsp_ready,
   output logic                                rsp_match_found,
   output logic      [ssu_pkg::MATCH_POS_W-1:0] rsp_match_position,
   output logic                                rsp_text_too_long,
   input  wire logic                           psel,
   input  wire logic                           penable,
   input  wire logic                           pwrite,
   input  wire logic [ssu_pkg::CSR_ADDR_W-1:0]  paddr,
   input  wire logic [ssu_pkg::CSR_DATA_W-1:0]  pwdata,
   output logic      [ssu_pkg::CSR_DATA_W-1:0]  prdata,
   output logic                                pready
);

   import ssu_pkg::*;

   localparam int LenW = $clog2(PATTERN_MAX + 1);
   localparam int CmpW = (POSITION_BITS > LIMIT_W) ? POSITION_BITS : LIMIT_W;

   cfg_type                  cfg;
   logic                     accept;
   logic [LenW-1:0]          len_eff;
   logic [PATTERN_MAX-1:0]   cell_now;
   logic [PATTERN_MAX-1:0]   cell_ff;
   logic [PATTERN_MAX-1:0]   tail_hit;
   logic                     hit;

   logic [POSITION_BITS:0]   count_ff;
   logic [POSITION_BITS:0]   count_in;
   logic                     have_ff;
   logic                     have_in;
   logic [POSITION_BITS-1:0] best_ff;
   logic [POSITION_BITS-1:0] best_in;
   logic                     ovf_ff;
   logic                     ovf_in;
   logic [POSITION_BITS:0]   start_full;
   logic [CmpW-1:0]          start_cmp;
   logic [CmpW-1:0]          limit_cmp;

   logic                     rsp_valid_ff;
   logic                     rsp_valid_in;
   logic                     found_ff;
   logic [MATCH_POS_W-1:0]   pos_ff;
   logic                     too_long_ff;

   ssu_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   always_comb begin
      if (cfg.length == '0) begin
         len_eff = LenW'(1);
      end else if (int'(cfg.length) > PATTERN_MAX) begin
         len_eff = LenW'(PATTERN_MAX);
      end else begin
         len_eff = LenW'(cfg.length);
      end
   end

   for (genvar k = 0; k < PATTERN_MAX; k++) begin : g_cell
      logic prev;
      if (k == 0) begin : g_head
         assign prev = 1'b1;
      end else begin : g_link
         assign prev = cell_ff[k-1];
      end
      ssu_cell u_cell (
         .clock        (clock),
         .reset        (reset),
         .advance      (accept),
         .flush        (req_end_of_text),
         .text_byte    (req_text_byte),
         .pattern_byte (pattern_byte(cfg.pattern, k)),
         .prev_match   (prev),
         .match_now    (cell_now[k]),
         .match_ff     (cell_ff[k])
      );
      assign tail_hit[k] = cell_now[k] && (len_eff == LenW'(k + 1));
   end

   assign hit        = |tail_hit;
   assign start_full = count_ff + (POSITION_BITS+1)'(1) - (POSITION_BITS+1)'(len_eff);
   assign start_cmp  = CmpW'(start_full[POSITION_BITS-1:0]);
   assign limit_cmp  = CmpW'(cfg.limit);

   always_comb begin
      count_in = count_ff;
      have_in  = have_ff;
      best_in  = best_ff;
      ovf_in   = ovf_ff;
      if (count_ff[POSITION_BITS]) begin
         ovf_in = 1'b1;
      end else begin
         count_in = count_ff + (POSITION_BITS+1)'(1);
         if (hit) begin
            if (cfg.backward) begin
               if (start_cmp <= limit_cmp) begin
                  have_in = 1'b1;
                  best_in = start_full[POSITION_BITS-1:0];
               end
            end else if (!have_ff && (start_cmp >= limit_cmp)) begin
               have_in = 1'b1;
               best_in = start_full[POSITION_BITS-1:0];
            end
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept && req_end_of_text) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         have_ff      <= 1'b0;
         best_ff      <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            if (req_end_of_text) begin
               count_ff <= '0;
               have_ff  <= 1'b0;
               best_ff  <= '0;
               ovf_ff   <= 1'b0;
            end else begin
               count_ff <= count_in;
               have_ff  <= have_in;
               best_ff  <= best_in;
               ovf_ff   <= ovf_in;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept && req_end_of_text) begin
         found_ff    <= have_in;
         pos_ff      <= have_in ? MATCH_POS_W'(best_in) : '0;
         too_long_ff <= ovf_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_match_found    = found_ff;
   assign rsp_match_position = pos_ff;
   assign rsp_text_too_long  = too_long_ff;

endmodule

`default_nettype wire

[rtl/core/ssu_checker.sv]
// Port-level checker for the substring search unit, bound to the top level.
`default_nettype none

module ssu_checker (
   input wire logic                           clock,
   input wire logic                           reset,
   input wire logic                           req_valid,
   input wire logic                           req_ready,
   input wire logic                           req_end_of_text,
   input wire logic                           rsp_valid,
   input wire logic                           rsp_ready,
   input wire logic                           rsp_match_found,
   input wire logic [ssu_pkg::MATCH_POS_W-1:0] rsp_match_position,
   input wire logic                           rsp_text_too_long
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_match_found)
         && $stable(rsp_match_position) && $stable(rsp_text_too_long))
      else $error("request result changed while stalled");

   a_no_match_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_match_found |-> rsp_match_position == '0)
      else $error("position nonzero without a match");

   a_end_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_end_of_text |=> rsp_valid)
      else $error("end of text request gave no result");

   a_no_spurious_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && !req_end_of_text && !rsp_valid |=> !rsp_valid)
      else $error("result without end of text request");

   a_ready_when_free: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("request stalled with empty result register");

endmodule

bind substring_search_unit ssu_checker u_ssu_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_valid),
   .req_ready          (req_ready),
   .req_end_of_text    (req_end_of_text),
   .rsp_valid          (rsp_valid),
   .rsp_ready          (rsp_ready),
   .rsp_match_found    (rsp_match_found),
   .rsp_match_position (rsp_match_position),
   .rsp_text_too_long  (rsp_text_too_long)
);

`default_nettype wire
